FILE: hdl/mp2a_pkg.sv
package mp2a_pkg;

    // fixed field widths of the block
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 12;
    localparam int DIM_W      = 7;
    localparam int KER_W      = 4;
    localparam int PAD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // padded extent (dimension plus both pads) and window coordinates
    localparam int PADDED_W = 8;
    localparam int COORD_W  = 13;

    // register reset values
    localparam logic [DIM_W-1:0] RESET_IN_HEIGHT     = 7'd8;
    localparam logic [DIM_W-1:0] RESET_IN_WIDTH      = 7'd8;
    localparam logic [KER_W-1:0] RESET_KERNEL_HEIGHT = 4'd2;
    localparam logic [KER_W-1:0] RESET_KERNEL_WIDTH  = 4'd2;
    localparam logic [KER_W-1:0] RESET_STRIDE_ROWS   = 4'd2;
    localparam logic [KER_W-1:0] RESET_STRIDE_COLS   = 4'd2;
    localparam logic [PAD_W-1:0] RESET_PAD_ROWS      = 3'd0;
    localparam logic [PAD_W-1:0] RESET_PAD_COLS      = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_KERNEL_HEIGHT = 3'd2,
        REG_KERNEL_WIDTH  = 3'd3,
        REG_STRIDE_ROWS   = 3'd4,
        REG_STRIDE_COLS   = 3'd5,
        REG_PAD_ROWS      = 3'd6,
        REG_PAD_COLS      = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SCAN,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_HEIGHT,
        DIV_WIDTH
    } div_state_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BASE,
        SCAN_ROW,
        SCAN_CELL,
        SCAN_DRAIN,
        SCAN_DONE
    } scan_state_t;

    // effective (clamped) geometry handed to the window scanner
    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
        logic [KER_W-1:0] kernel_height;
        logic [KER_W-1:0] kernel_width;
        logic [KER_W-1:0] stride_rows;
        logic [KER_W-1:0] stride_cols;
        logic [PAD_W-1:0] pad_rows;
        logic [PAD_W-1:0] pad_cols;
    } geom_t;

    // window scan outcome
    typedef struct packed {
        logic                       done;
        logic                       found;
        logic signed [SAMPLE_W-1:0] value;
    } scan_result_t;

endpackage

FILE: hdl/max_pool_2d_with_argmax_unit.sv
// Max pooling with argmax over one stored plane of 16-bit signed samples. A load transaction
// (action 0) writes the next pixel in raster order; the load position wraps after
// in_height*in_width pixels. A fetch transaction (action 1) returns the next pooled output
// in raster order: the window maximum, the flat position row*in_width+column of the first
// maximum, a found flag (0 when the window covers padding only) and last on the final
// output of the plane. A fetch places the window, walks it one cell per cycle through the
// single read port of the plane store, drains the last read and hands the result to the
// output register once that register is free; the next transaction is taken after the
// handover. When the kernel exceeds the padded plane every fetch returns status 1 with
// last set. After reset and after every register write the output size is recomputed by
// a shared bit-serial divider, and s_ready stays low until it finishes; a register write
// also restarts the load and output positions.
module max_pool_2d_with_argmax_unit
    import mp2a_pkg::*;
#(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_KERNEL = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic signed [SAMPLE_W-1:0]  s_pixel_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_max_value,
    output logic [POS_W-1:0]            m_max_position,
    output logic                        m_found,
    output logic                        m_status,
    output logic                        m_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [DIM_W-1:0] cfg_in_height_reg, cfg_in_width_reg;
    logic [KER_W-1:0] cfg_kernel_height_reg, cfg_kernel_width_reg;
    logic [KER_W-1:0] cfg_stride_rows_reg, cfg_stride_cols_reg;
    logic [PAD_W-1:0] cfg_pad_rows_reg, cfg_pad_cols_reg;

    top_state_t                 state_reg, state_next;
    logic                       boot_reg;
    logic                       cfg_pend_reg;
    logic                       cfg_bad_reg;
    logic [2*DIM_W-1:0]         plane_size_reg;
    logic [DIM_W-1:0]           out_height_reg, out_width_reg;
    logic [DIM_W-1:0]           out_row_reg, out_col_reg;
    logic [ADDR_W-1:0]          load_pos_reg;
    logic                       bad_pend_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_max_value_reg;
    logic [POS_W-1:0]           m_max_position_reg;
    logic                       m_found_reg, m_status_reg, m_last_reg;

    geom_t                      geom;
    logic [PADDED_W-1:0]        padded_rows, padded_cols;
    logic                       cfg_bad;
    logic                       cfg_fire, s_fire, load_fire, fetch_fire;
    logic                       load_wrap;
    logic                       out_load, last_out, col_end;
    logic                       scan_start;
    logic                       div_start, div_busy, div_done;
    logic [PADDED_W-1:0]        quotient_rows, quotient_cols;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SAMPLE_W-1:0]        rd_data;
    scan_result_t               scan_res;
    logic [ADDR_W-1:0]          scan_pos;

    // clamped geometry
    always_comb begin
        if (cfg_in_height_reg == '0) geom.height = DIM_W'(1);
        else if (int'(cfg_in_height_reg) > MAX_HEIGHT) geom.height = DIM_W'(MAX_HEIGHT);
        else geom.height = cfg_in_height_reg;

        if (cfg_in_width_reg == '0) geom.width = DIM_W'(1);
        else if (int'(cfg_in_width_reg) > MAX_WIDTH) geom.width = DIM_W'(MAX_WIDTH);
        else geom.width = cfg_in_width_reg;

        if (cfg_kernel_height_reg == '0) geom.kernel_height = KER_W'(1);
        else if (int'(cfg_kernel_height_reg) > MAX_KERNEL)
            geom.kernel_height = KER_W'(MAX_KERNEL);
        else geom.kernel_height = cfg_kernel_height_reg;

        if (cfg_kernel_width_reg == '0) geom.kernel_width = KER_W'(1);
        else if (int'(cfg_kernel_width_reg) > MAX_KERNEL)
            geom.kernel_width = KER_W'(MAX_KERNEL);
        else geom.kernel_width = cfg_kernel_width_reg;

        geom.stride_rows = (cfg_stride_rows_reg == '0) ? KER_W'(1) : cfg_stride_rows_reg;
        geom.stride_cols = (cfg_stride_cols_reg == '0) ? KER_W'(1) : cfg_stride_cols_reg;
        geom.pad_rows    = cfg_pad_rows_reg;
        geom.pad_cols    = cfg_pad_cols_reg;
    end

    // padded extent and kernel fit check
    assign padded_rows = PADDED_W'(geom.height) + PADDED_W'({cfg_pad_rows_reg, 1'b0});
    assign padded_cols = PADDED_W'(geom.width) + PADDED_W'({cfg_pad_cols_reg, 1'b0});
    assign cfg_bad     = (PADDED_W'(geom.kernel_height) > padded_rows) ||
                         (PADDED_W'(geom.kernel_width) > padded_cols);

    // handshakes; the divider starts in the cycle after a register write so it sees the new value
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (action_t'(s_action) == ACT_LOAD);
    assign fetch_fire = s_fire && (action_t'(s_action) == ACT_FETCH);
    assign div_start  = boot_reg || cfg_pend_reg;
    assign load_wrap  = (32'(load_pos_reg) + 32'd1) >= 32'(plane_size_reg);

    // output position bookkeeping
    assign last_out = ({1'b0, out_row_reg} + 8'd1 >= {1'b0, out_height_reg}) &&
                      ({1'b0, out_col_reg} + 8'd1 >= {1'b0, out_width_reg});
    assign col_end  = ({1'b0, out_col_reg} + 8'd1 >= {1'b0, out_width_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE: begin
                if (fetch_fire) state_next = cfg_bad_reg ? TOP_EMIT : TOP_SCAN;
            end
            TOP_SCAN: begin
                if (scan_res.done) state_next = TOP_EMIT;
            end
            TOP_EMIT: begin
                if (!m_valid_reg || m_ready) state_next = TOP_IDLE;
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready    = (state_reg == TOP_IDLE) && !div_busy && !boot_reg && !cfg_pend_reg;
        scan_start = fetch_fire && !cfg_bad_reg;
        out_load   = (state_reg == TOP_EMIT) && (!m_valid_reg || m_ready);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= TOP_IDLE;
            boot_reg              <= 1'b1;
            cfg_pend_reg          <= 1'b0;
            m_valid_reg           <= 1'b0;
            cfg_in_height_reg     <= RESET_IN_HEIGHT;
            cfg_in_width_reg      <= RESET_IN_WIDTH;
            cfg_kernel_height_reg <= RESET_KERNEL_HEIGHT;
            cfg_kernel_width_reg  <= RESET_KERNEL_WIDTH;
            cfg_stride_rows_reg   <= RESET_STRIDE_ROWS;
            cfg_stride_cols_reg   <= RESET_STRIDE_COLS;
            cfg_pad_rows_reg      <= RESET_PAD_ROWS;
            cfg_pad_cols_reg      <= RESET_PAD_COLS;
            out_height_reg        <= '0;
            out_width_reg         <= '0;
            out_row_reg           <= '0;
            out_col_reg           <= '0;
            load_pos_reg          <= '0;
            bad_pend_reg          <= 1'b0;
        end else begin
            state_reg    <= state_next;
            boot_reg     <= 1'b0;
            cfg_pend_reg <= cfg_fire;

            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            if (fetch_fire) bad_pend_reg <= cfg_bad_reg;

            // register writes
            if (cfg_fire) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IN_HEIGHT:     cfg_in_height_reg     <= cfg_data[DIM_W-1:0];
                    REG_IN_WIDTH:      cfg_in_width_reg      <= cfg_data[DIM_W-1:0];
                    REG_KERNEL_HEIGHT: cfg_kernel_height_reg <= cfg_data[KER_W-1:0];
                    REG_KERNEL_WIDTH:  cfg_kernel_width_reg  <= cfg_data[KER_W-1:0];
                    REG_STRIDE_ROWS:   cfg_stride_rows_reg   <= cfg_data[KER_W-1:0];
                    REG_STRIDE_COLS:   cfg_stride_cols_reg   <= cfg_data[KER_W-1:0];
                    REG_PAD_ROWS:      cfg_pad_rows_reg      <= cfg_data[PAD_W-1:0];
                    REG_PAD_COLS:      cfg_pad_cols_reg      <= cfg_data[PAD_W-1:0];
                    default: begin
                    end
                endcase
            end

            // output size from the divider
            if (div_done) begin
                out_height_reg <= cfg_bad_reg ? '0 : quotient_rows[DIM_W-1:0] + DIM_W'(1);
                out_width_reg  <= cfg_bad_reg ? '0 : quotient_cols[DIM_W-1:0] + DIM_W'(1);
            end

            // load position
            if (cfg_fire) load_pos_reg <= '0;
            else if (load_fire) load_pos_reg <= load_wrap ? '0 : load_pos_reg + ADDR_W'(1);

            // output position advances on each good result
            if (cfg_fire) begin
                out_row_reg <= '0;
                out_col_reg <= '0;
            end else if (out_load && !bad_pend_reg) begin
                if (last_out) begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end else if (col_end) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + DIM_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + DIM_W'(1);
                end
            end
        end
    end

    // derived configuration, settled long before the divider finishes
    always_ff @(posedge aclk) begin
        cfg_bad_reg    <= cfg_bad;
        plane_size_reg <= (2*DIM_W)'(geom.height) * (2*DIM_W)'(geom.width);
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (bad_pend_reg) begin
                m_max_value_reg    <= '0;
                m_max_position_reg <= '0;
                m_found_reg        <= 1'b0;
                m_status_reg       <= 1'b1;
                m_last_reg         <= 1'b1;
            end else begin
                m_max_value_reg    <= scan_res.value;
                m_max_position_reg <= POS_W'(scan_pos);
                m_found_reg        <= scan_res.found;
                m_status_reg       <= 1'b0;
                m_last_reg         <= last_out;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_max_value    = m_max_value_reg;
    assign m_max_position = m_max_position_reg;
    assign m_found        = m_found_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;

    // output size divider
    mp2a_div u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (div_start),
        .dividend_rows (padded_rows - PADDED_W'(geom.kernel_height)),
        .dividend_cols (padded_cols - PADDED_W'(geom.kernel_width)),
        .divisor_rows  (geom.stride_rows),
        .divisor_cols  (geom.stride_cols),
        .busy          (div_busy),
        .done          (div_done),
        .quotient_rows (quotient_rows),
        .quotient_cols (quotient_cols)
    );

    // plane store
    mp2a_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_fire),
        .wr_addr (load_pos_reg),
        .wr_data (s_pixel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // window scanner
    mp2a_scan #(
        .ADDR_W (ADDR_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .geom     (geom),
        .out_row  (out_row_reg),
        .out_col  (out_col_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .result   (scan_res),
        .best_pos (scan_pos)
    );

endmodule

FILE: hdl/mp2a_ram.sv
module mp2a_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/mp2a_div.sv
module mp2a_div
    import mp2a_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PADDED_W-1:0] dividend_rows,
    input  logic [PADDED_W-1:0] dividend_cols,
    input  logic [KER_W-1:0]    divisor_rows,
    input  logic [KER_W-1:0]    divisor_cols,
    output logic                busy,
    output logic                done,
    output logic [PADDED_W-1:0] quotient_rows,
    output logic [PADDED_W-1:0] quotient_cols
);

    localparam int STEP_W = $clog2(PADDED_W);

    div_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [PADDED_W-1:0] num_reg;
    logic [KER_W-1:0]    rem_reg;
    logic                done_reg;
    logic [PADDED_W-1:0] quotient_rows_reg;
    logic [PADDED_W-1:0] quotient_cols_reg;

    logic                last_step;
    logic [KER_W-1:0]    divisor_cur;
    logic [KER_W:0]      rem_shift;
    logic [KER_W:0]      rem_sub;
    logic                fits;
    logic [KER_W-1:0]    rem_next;
    logic [PADDED_W-1:0] num_next;

    // one restoring division step per cycle, rows first then columns
    assign last_step   = (step_reg == STEP_W'(PADDED_W - 1));
    assign divisor_cur = (state_reg == DIV_WIDTH) ? divisor_cols : divisor_rows;
    assign rem_shift   = {rem_reg, num_reg[PADDED_W-1]};
    assign rem_sub     = rem_shift - {1'b0, divisor_cur};
    assign fits        = (rem_shift >= {1'b0, divisor_cur});
    assign rem_next    = fits ? rem_sub[KER_W-1:0] : rem_shift[KER_W-1:0];
    assign num_next    = {num_reg[PADDED_W-2:0], fits};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) state_next = DIV_HEIGHT;
            end
            DIV_HEIGHT: begin
                if (start) state_next = DIV_HEIGHT;
                else if (last_step) state_next = DIV_WIDTH;
            end
            DIV_WIDTH: begin
                if (start) state_next = DIV_HEIGHT;
                else if (last_step) state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy = (state_reg != DIV_IDLE) || done_reg;
        done = done_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DIV_WIDTH) && last_step && !start;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            num_reg  <= dividend_rows;
            rem_reg  <= '0;
        end else if (state_reg != DIV_IDLE) begin
            if (last_step) begin
                step_reg <= '0;
                num_reg  <= dividend_cols;
                rem_reg  <= '0;
                if (state_reg == DIV_HEIGHT) begin
                    quotient_rows_reg <= num_next;
                end else begin
                    quotient_cols_reg <= num_next;
                end
            end else begin
                step_reg <= step_reg + STEP_W'(1);
                num_reg  <= num_next;
                rem_reg  <= rem_next;
            end
        end
    end

    assign quotient_rows = quotient_rows_reg;
    assign quotient_cols = quotient_cols_reg;

endmodule

FILE: hdl/mp2a_scan.sv
module mp2a_scan
    import mp2a_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  geom_t                      geom,
    input  logic [DIM_W-1:0]           out_row,
    input  logic [DIM_W-1:0]           out_col,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  logic signed [SAMPLE_W-1:0] rd_data,
    output scan_result_t               result,
    output logic [ADDR_W-1:0]          best_pos
);

    localparam int ROW_W = COORD_W + DIM_W + 1;

    scan_state_t                state_reg, state_next;
    logic [KER_W-1:0]           i_reg, j_reg;
    logic signed [COORD_W-1:0]  base_r_reg, base_c_reg;
    logic signed [COORD_W-1:0]  cur_r_reg, cur_c_reg;
    logic signed [ROW_W-1:0]    row_addr_reg;
    logic                       pend_valid_reg;
    logic [ADDR_W-1:0]          pend_pos_reg;
    logic                       found_reg;
    logic signed [SAMPLE_W-1:0] best_reg;
    logic [ADDR_W-1:0]          best_pos_reg;

    logic [COORD_W-1:0]         prod_r, prod_c;
    logic signed [COORD_W-1:0]  height_s, width_s;
    logic                       r_ok, c_ok, cell_ok;
    logic                       col_end, row_last;
    logic signed [ROW_W-1:0]    addr_full;
    logic                       take;

    // window origin in padded-plane coordinates; the pads are subtracted in SCAN_BASE
    assign prod_r = COORD_W'(out_row) * COORD_W'(geom.stride_rows);
    assign prod_c = COORD_W'(out_col) * COORD_W'(geom.stride_cols);

    // padding cells are skipped, real cells are read
    assign height_s  = signed'(COORD_W'(geom.height));
    assign width_s   = signed'(COORD_W'(geom.width));
    assign r_ok      = !cur_r_reg[COORD_W-1] && (cur_r_reg < height_s);
    assign c_ok      = !cur_c_reg[COORD_W-1] && (cur_c_reg < width_s);
    assign cell_ok   = r_ok && c_ok;
    assign addr_full = row_addr_reg + ROW_W'(cur_c_reg);
    assign col_end   = (j_reg == geom.kernel_width - KER_W'(1));
    assign row_last  = (i_reg == geom.kernel_height - KER_W'(1));

    // strictly greater keeps the first maximum in scan order
    assign take = pend_valid_reg && (!found_reg || (rd_data > best_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE: begin
                if (start) state_next = SCAN_BASE;
            end
            SCAN_BASE:  state_next = SCAN_ROW;
            SCAN_ROW:   state_next = SCAN_CELL;
            SCAN_CELL: begin
                if (col_end && row_last) state_next = SCAN_DRAIN;
            end
            SCAN_DRAIN: state_next = SCAN_DONE;
            SCAN_DONE:  state_next = SCAN_IDLE;
            default:    state_next = SCAN_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        rd_en        = (state_reg == SCAN_CELL) && cell_ok;
        rd_addr      = addr_full[ADDR_W-1:0];
        result.done  = (state_reg == SCAN_DONE);
        result.found = found_reg;
        result.value = best_reg;
        best_pos     = best_pos_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SCAN_IDLE;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= rd_en;
        end
    end

    // window walk, one cell a cycle
    always_ff @(posedge aclk) begin
        pend_pos_reg <= rd_addr;
        unique case (state_reg)
            SCAN_BASE: begin
                base_r_reg <= signed'(prod_r - COORD_W'(geom.pad_rows));
                base_c_reg <= signed'(prod_c - COORD_W'(geom.pad_cols));
            end
            SCAN_ROW: begin
                row_addr_reg <= ROW_W'(base_r_reg) * ROW_W'(width_s);
                cur_r_reg    <= base_r_reg;
                cur_c_reg    <= base_c_reg;
                i_reg        <= '0;
                j_reg        <= '0;
            end
            SCAN_CELL: begin
                if (col_end) begin
                    j_reg        <= '0;
                    cur_c_reg    <= base_c_reg;
                    i_reg        <= i_reg + KER_W'(1);
                    cur_r_reg    <= cur_r_reg + COORD_W'(1);
                    row_addr_reg <= row_addr_reg + ROW_W'(width_s);
                end else begin
                    j_reg     <= j_reg + KER_W'(1);
                    cur_c_reg <= cur_c_reg + COORD_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // running maximum with its position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (state_reg == SCAN_BASE) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SCAN_BASE) begin
            best_reg     <= '0;
            best_pos_reg <= '0;
        end else if (take) begin
            best_reg     <= rd_data;
            best_pos_reg <= pend_pos_reg;
        end
    end

endmodule

FILE: hdl/mp2a_check.sv
module mp2a_check
    import mp2a_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_action,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_max_value,
    input logic [POS_W-1:0]           m_max_position,
    input logic                       m_found,
    input logic                       m_status,
    input logic                       m_last
);

    // reset leaves no result pending and holds off input while sizes settle
    assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("result or input ready right after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_value) &&
            $stable(m_max_position) && $stable(m_found) && $stable(m_last))
        else $error("stalled result changed");

    // bad geometry reports as a closing empty result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last && !m_found)
        else $error("bad status without last or with found");

    // an empty window reports zero value and zero position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_max_value == '0) && (m_max_position == '0))
        else $error("empty window with nonzero payload");

    // a load transaction never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (action_t'(s_action) == ACT_LOAD) && !m_valid |=> !m_valid)
        else $error("load produced a result");

endmodule

bind max_pool_2d_with_argmax_unit mp2a_check u_check (.*);
